>>> rtl/core/ctb_pkg.sv
// Shared sizes, entry type and ring control struct for the circular event trace buffer.
package ctb_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 2048;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    // Entry fields
    localparam int LANES      = 8;
    localparam int LANE_W     = 8;
    localparam int PAYLOAD_W  = LANES * LANE_W;
    localparam int TS_W       = 28;

    typedef logic [PTR_W-1:0]     t_ptr;
    typedef logic [PAYLOAD_W-1:0] t_payload;
    typedef logic [TS_W-1:0]      t_stamp;

    typedef struct packed {
        t_payload payload;
        t_stamp   stamp;
    } t_entry;

    // Port controls from the top level to the ring memory
    typedef struct packed {
        logic wr_en;
        t_ptr wr_addr;
        logic rd_en;
        t_ptr rd_addr;
    } t_ring_ctl;

    // Advance a ring pointer with wrap at the last entry
    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr q;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

endpackage

>>> rtl/core/ctb_if.sv
// Request channel interfaces: event ticks in, drained entries out.
interface ctb_in_if;
    logic                               valid;
    logic                               ready;
    logic [ctb_pkg::LANES-1:0]          lane_valid;
    logic [ctb_pkg::PAYLOAD_W-1:0]      lane_bytes;
    logic                               mode_write;
    logic                               drain_select;

    modport source (output valid, output lane_valid, output lane_bytes,
                    output mode_write, output drain_select, input ready);
    modport sink   (input valid, input lane_valid, input lane_bytes,
                    input mode_write, input drain_select, output ready);
endinterface

interface ctb_out_if;
    logic                               valid;
    logic                               ready;
    logic [ctb_pkg::PAYLOAD_W-1:0]      entry_payload;
    logic [ctb_pkg::TS_W-1:0]           entry_timestamp;

    modport source (output valid, output entry_payload, output entry_timestamp, input ready);
    modport sink   (input valid, input entry_payload, input entry_timestamp, output ready);
endinterface

>>> rtl/core/ctb_ring.sv
// Trace ring storage: one write port, one registered read port.
module ctb_ring (
    input  logic               i_clk,
    input  ctb_pkg::t_ring_ctl i_ctl,
    input  ctb_pkg::t_entry    i_wr_data,
    output ctb_pkg::t_entry    o_rd_data
);

    ctb_pkg::t_entry r_mem [ctb_pkg::RING_DEPTH];
    ctb_pkg::t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
    end

    // Read port; data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/circular_event_trace_buffer_core.sv
// Top level of the circular event trace buffer.
//
// Usage: each request on i_evt is one trace tick carrying eight optional
// event bytes (lane_valid/lane_bytes) and an optional mode change
// (mode_write/drain_select). A tick with any valid lane is logged into a
// ring of RING_DEPTH entries with the low 28 bits of a tick counter; when
// the ring fills, the oldest entry is dropped, so it holds RING_DEPTH-1.
// In drain mode each tick first emits the oldest entry, if any, on o_ent.
// Throughput: one tick per cycle, save a draining tick that waits on o_ent.ready. Pointer updates are decided from
// registers at acceptance; the ring memory is written and read in the
// same cycle at distinct addresses, so no interlock is needed.
// Latency: a drained entry appears on o_ent the cycle after its tick is
// accepted, straight from the ring's registered read port.
// Stall: while a result waits on o_ent, ticks that drain nothing are
// still taken; a tick that would drain waits for o_ent.ready.
// Reset (synchronous, i_rst_n low): pointers, tick counter and mode go
// to zero (record mode) and the output is emptied; ring contents are
// left as they are and no clearing pass is run.
module circular_event_trace_buffer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctb_in_if.sink    i_evt,
    ctb_out_if.source o_ent
);

    ctb_pkg::t_ptr      r_rptr, n_rptr;
    ctb_pkg::t_ptr      r_wptr, n_wptr;
    ctb_pkg::t_stamp    r_tick;
    logic               r_drain_mode;
    logic               r_out_vld, n_out_vld;

    logic               w_drain;
    logic               w_log;
    logic               w_acc;
    logic               w_out_busy;
    ctb_pkg::t_ptr      w_rptr_drained;
    ctb_pkg::t_payload  w_payload;
    ctb_pkg::t_ring_ctl w_ctl;
    ctb_pkg::t_entry    w_wr_data;
    ctb_pkg::t_entry    w_rd_data;

    // Tick decode
    assign w_drain    = r_drain_mode && (r_rptr != r_wptr);
    assign w_log      = |i_evt.lane_valid;
    assign w_out_busy = r_out_vld && !o_ent.ready;
    assign i_evt.ready = !(w_out_busy && w_drain);
    assign w_acc      = i_evt.valid && i_evt.ready;

    // Absent lanes log as zero
    always_comb begin
        for (int l = 0; l < ctb_pkg::LANES; l++) begin
            w_payload[l*ctb_pkg::LANE_W +: ctb_pkg::LANE_W] =
                i_evt.lane_valid[l] ? i_evt.lane_bytes[l*ctb_pkg::LANE_W +: ctb_pkg::LANE_W]
                                    : '0;
        end
    end

    // Pointer update: drain first, then log, then drop oldest on overflow
    always_comb begin
        w_rptr_drained = w_drain ? ctb_pkg::ptr_next(r_rptr) : r_rptr;
        n_wptr         = w_log ? ctb_pkg::ptr_next(r_wptr) : r_wptr;
        n_rptr         = w_rptr_drained;
        if (w_log && (n_wptr == w_rptr_drained)) begin
            n_rptr = ctb_pkg::ptr_next(w_rptr_drained);
        end
    end

    // Ring port controls
    always_comb begin
        w_ctl.wr_en   = w_acc && w_log;
        w_ctl.wr_addr = r_wptr;
        w_ctl.rd_en   = w_acc && w_drain;
        w_ctl.rd_addr = r_rptr;
        w_wr_data.payload = w_payload;
        w_wr_data.stamp   = r_tick;
    end

    ctb_ring u_ring (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // Output valid: set by a draining tick, cleared when taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_acc && w_drain) begin
            n_out_vld = 1'b1;
        end else if (o_ent.ready) begin
            n_out_vld = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr       <= '0;
            r_wptr       <= '0;
            r_tick       <= '0;
            r_drain_mode <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            if (w_acc) begin
                r_rptr <= n_rptr;
                r_wptr <= n_wptr;
                r_tick <= r_tick + ctb_pkg::TS_W'(1);
                if (i_evt.mode_write) begin
                    r_drain_mode <= i_evt.drain_select;
                end
            end
        end
    end

    assign o_ent.valid           = r_out_vld;
    assign o_ent.entry_payload   = w_rd_data.payload;
    assign o_ent.entry_timestamp = w_rd_data.stamp;

    // Checks
    a_rw_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.rd_en && w_ctl.wr_en) |-> (w_ctl.rd_addr != w_ctl.wr_addr))
        else $error("ring read and write hit the same entry");

    a_drain_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_drain) |=> r_out_vld)
        else $error("drained entry not presented");

    a_log_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_log) |=> (r_rptr != r_wptr))
        else $error("ring empty after logging");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_busy && w_drain) |-> !w_ctl.rd_en)
        else $error("pending result overwritten");

    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_tick == $past(r_tick) + ctb_pkg::TS_W'(1)))
        else $error("tick counter did not advance by one");

endmodule

>>> bench/circular_event_trace_buffer_core_tb.sv
// Self-checking testbench for the circular event trace buffer: directed ticks, random ticks, record and drain phases.
module circular_event_trace_buffer_core_tb;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RESET_CYCLES   = 6;

    typedef logic [ctb_pkg::LANES-1:0] t_lanes;

    // One trace tick as driven on the request channel
    typedef struct packed {
        t_lanes            lanes;
        ctb_pkg::t_payload bytes;
        logic              mode_wr;
        logic              drain_sel;
    } t_trace_tick;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_ENTRY
    } t_row_check;

    typedef struct {
        t_trace_tick     tick;
        t_row_check      chk;
        ctb_pkg::t_entry want;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    ctb_in_if  tick_bus ();
    ctb_out_if entry_bus ();

    circular_event_trace_buffer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (tick_bus),
        .o_ent   (entry_bus)
    );

    // Shadow copy of the ring and its control state
    ctb_pkg::t_entry ring_copy [ctb_pkg::RING_DEPTH];
    ctb_pkg::t_ptr   oldest_ptr;
    ctb_pkg::t_ptr   write_ptr;
    ctb_pkg::t_stamp tick_count;
    logic            in_drain;

    ctb_pkg::t_entry drained_queue [$];
    t_directed_row   directed_rows [$];

    int mismatch_count;
    int ticks_sent;
    int entries_seen;
    int overflow_drops;
    int ring_wraps;
    int max_gap;
    int max_stall;
    int idle_cycles;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic ctb_pkg::t_ptr ring_step(input ctb_pkg::t_ptr p);
        return (p == ctb_pkg::t_ptr'(ctb_pkg::RING_DEPTH - 1)) ? ctb_pkg::t_ptr'(0)
                                                               : ctb_pkg::t_ptr'(p + 1'b1);
    endfunction

    // Apply one accepted tick to the shadow ring; returns 1 if an entry drains
    function automatic bit apply_tick(input t_trace_tick t, output ctb_pkg::t_entry drained);
        bit              emits;
        ctb_pkg::t_entry logged;
        emits   = 1'b0;
        drained = '0;
        // drain reads before this tick's entry is written
        if (in_drain && (oldest_ptr != write_ptr)) begin
            drained    = ring_copy[oldest_ptr];
            oldest_ptr = ring_step(oldest_ptr);
            emits      = 1'b1;
        end
        if (t.lanes != '0) begin
            logged = '0;
            for (int lane = 0; lane < ctb_pkg::LANES; lane++) begin
                if (t.lanes[lane]) begin
                    logged.payload[lane*ctb_pkg::LANE_W +: ctb_pkg::LANE_W] =
                        t.bytes[lane*ctb_pkg::LANE_W +: ctb_pkg::LANE_W];
                end
            end
            logged.stamp         = tick_count;
            ring_copy[write_ptr] = logged;
            write_ptr            = ring_step(write_ptr);
            if (write_ptr == '0) begin
                ring_wraps++;
            end
            // full ring: oldest entry is lost
            if (write_ptr == oldest_ptr) begin
                oldest_ptr = ring_step(oldest_ptr);
                overflow_drops++;
            end
        end
        if (t.mode_wr) begin
            in_drain = t.drain_sel;
        end
        tick_count = tick_count + 1'b1;
        return emits;
    endfunction

    function automatic t_trace_tick random_tick(input int drain_pct);
        t_trace_tick t;
        int          pick;
        pick = $urandom_range(0, 7);
        if (pick < 2) begin
            t.lanes = '0;
        end else if (pick == 2) begin
            t.lanes = '1;
        end else begin
            t.lanes = t_lanes'($urandom_range(0, 255));
        end
        t.bytes     = {$urandom, $urandom};
        t.mode_wr   = ($urandom_range(0, 7) == 0);
        t.drain_sel = ($urandom_range(0, 99) < drain_pct);
        return t;
    endfunction

    task automatic add_row(input t_lanes lanes, input ctb_pkg::t_payload bytes,
                           input logic mode_wr, input logic drain_sel,
                           input t_row_check chk, input ctb_pkg::t_payload pl,
                           input ctb_pkg::t_stamp st);
        t_directed_row r;
        r.tick.lanes     = lanes;
        r.tick.bytes     = bytes;
        r.tick.mode_wr   = mode_wr;
        r.tick.drain_sel = drain_sel;
        r.chk            = chk;
        r.want.payload   = pl;
        r.want.stamp     = st;
        directed_rows.push_back(r);
    endtask

    // Offer one tick after a random gap and log its expected drain once accepted
    task automatic send_tick(input t_trace_tick t, input t_row_check chk,
                             input ctb_pkg::t_entry want);
        int              gap;
        bit              emits;
        ctb_pkg::t_entry drained;
        gap = $urandom_range(0, max_gap);
        if (gap != 0) begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_bus.valid        <= 1'b1;
        tick_bus.lane_valid   <= t.lanes;
        tick_bus.lane_bytes   <= t.bytes;
        tick_bus.mode_write   <= t.mode_wr;
        tick_bus.drain_select <= t.drain_sel;
        do @(posedge i_clk); while (tick_bus.ready !== 1'b1);
        emits = apply_tick(t, drained);
        case (chk)
            CHK_PREDICT: begin
                if (emits) begin
                    drained_queue.push_back(drained);
                end
            end
            CHK_ENTRY: drained_queue.push_back(want);
            default: ;
        endcase
        ticks_sent++;
    endtask

    // Hold the sender off until every expected entry has been drained
    task automatic hold_until_drained();
        tick_bus.valid <= 1'b0;
        do @(posedge i_clk); while (drained_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random stall per request, ready held high otherwise
    initial begin
        int stall;
        entry_bus.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = $urandom_range(0, max_stall);
            if (stall != 0) begin
                entry_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            entry_bus.ready <= 1'b1;
            do @(posedge i_clk); while (entry_bus.valid !== 1'b1);
        end
    end

    // Compare drained entries against the oldest expectation
    always @(posedge i_clk) begin
        ctb_pkg::t_entry want;
        if (entry_bus.valid === 1'b1 && entry_bus.ready === 1'b1) begin
            entries_seen++;
            if (drained_queue.size() == 0) begin
                report_mismatch($sformatf("entry %h/%h with nothing expected",
                                          entry_bus.entry_payload, entry_bus.entry_timestamp));
            end else begin
                want = drained_queue.pop_front();
                if (entry_bus.entry_payload !== want.payload) begin
                    report_mismatch($sformatf("payload %h, expected %h",
                                              entry_bus.entry_payload, want.payload));
                end
                if (entry_bus.entry_timestamp !== want.stamp) begin
                    report_mismatch($sformatf("timestamp %h, expected %h",
                                              entry_bus.entry_timestamp, want.stamp));
                end
            end
        end
    end

    // Watchdog on cycles with no request moving either way
    always @(posedge i_clk) begin
        if ((tick_bus.valid === 1'b1 && tick_bus.ready === 1'b1) ||
            (entry_bus.valid === 1'b1 && entry_bus.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request for %0d cycles, %0d entries outstanding",
                         idle_cycles, drained_queue.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_trace_tick     t;
        ctb_pkg::t_entry none;

        i_rst_n               <= 1'b0;
        tick_bus.valid        <= 1'b0;
        tick_bus.lane_valid   <= '0;
        tick_bus.lane_bytes   <= '0;
        tick_bus.mode_write   <= 1'b0;
        tick_bus.drain_select <= 1'b0;

        mismatch_count = 0;
        ticks_sent     = 0;
        entries_seen   = 0;
        overflow_drops = 0;
        ring_wraps     = 0;
        idle_cycles    = 0;
        max_gap        = 8;
        max_stall      = 8;
        oldest_ptr     = '0;
        write_ptr      = '0;
        tick_count     = '0;
        in_drain       = 1'b0;
        none           = '0;

        // Directed ticks; stamps count from the first tick after reset
        add_row(8'h00, 64'h0, 1'b1, 1'b1, CHK_NONE, 64'h0, 28'd0);   // drain, ring empty
        add_row(8'h00, 64'h0, 1'b0, 1'b0, CHK_NONE, 64'h0, 28'd0);   // empty ring in drain mode
        add_row(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, CHK_NONE, 64'h0, 28'd0);
        add_row(8'h01, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, CHK_NONE, 64'h0, 28'd0);
        add_row(8'h80, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, CHK_NONE, 64'h0, 28'd0);
        add_row(8'hAA, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, CHK_NONE, 64'h0, 28'd0);
        add_row(8'h55, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, CHK_NONE, 64'h0, 28'd0);
        add_row(8'h00, 64'h0, 1'b0, 1'b0, CHK_ENTRY, 64'hFFFF_FFFF_FFFF_FFFF, 28'd2);
        // drain and log in one tick: drained entry is the older one
        add_row(8'hFF, 64'h0, 1'b0, 1'b0, CHK_ENTRY, 64'h0000_0000_0000_00FF, 28'd3);
        add_row(8'h00, 64'h0, 1'b0, 1'b0, CHK_ENTRY, 64'hFF00_0000_0000_0000, 28'd4);
        add_row(8'h00, 64'h0, 1'b0, 1'b0, CHK_ENTRY, 64'h0100_4500_8900_CD00, 28'd5);
        add_row(8'h00, 64'h0, 1'b0, 1'b0, CHK_ENTRY, 64'h00FF_00FF_00FF_00FF, 28'd6);
        add_row(8'h00, 64'h0, 1'b0, 1'b0, CHK_ENTRY, 64'h0, 28'd8);
        add_row(8'h00, 64'h0, 1'b0, 1'b0, CHK_NONE, 64'h0, 28'd0);
        add_row(8'h01, 64'hFFFF_FFFF_FFFF_FF5A, 1'b1, 1'b0, CHK_NONE, 64'h0, 28'd0);
        // mode change lands on the next tick
        add_row(8'h00, 64'h0, 1'b1, 1'b1, CHK_NONE, 64'h0, 28'd0);
        add_row(8'h02, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 1'b0, CHK_ENTRY, 64'h5A, 28'd14);
        add_row(8'hFF, 64'h8000_0000_0000_0001, 1'b1, 1'b0, CHK_ENTRY, 64'hA500, 28'd16);
        // drain_select without mode_write is ignored
        add_row(8'h00, 64'h0, 1'b0, 1'b1, CHK_NONE, 64'h0, 28'd0);
        add_row(8'hC3, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b1, CHK_PREDICT, 64'h0, 28'd0);
        add_row(8'h00, 64'h0, 1'b0, 1'b0, CHK_PREDICT, 64'h0, 28'd0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_tick(directed_rows[i].tick, directed_rows[i].chk, directed_rows[i].want);
        end

        // Mixed random ticks with idling on both sides
        repeat (400) begin
            send_tick(random_tick(50), CHK_PREDICT, none);
        end
        hold_until_drained();

        // Back-to-back stretch, no idling
        max_gap   = 0;
        max_stall = 0;
        repeat (200) begin
            send_tick(random_tick(50), CHK_PREDICT, none);
        end

        // Build up a deep backlog in record mode
        max_gap = 1;
        t       = random_tick(0);
        t.mode_wr   = 1'b1;
        t.drain_sel = 1'b0;
        send_tick(t, CHK_PREDICT, none);
        repeat (400) begin
            t         = random_tick(0);
            t.lanes   = t_lanes'($urandom_range(1, 255));
            t.mode_wr = 1'b0;
            send_tick(t, CHK_PREDICT, none);
        end

        // Drain the backlog under receiver stalls, mostly in drain mode
        max_gap   = 8;
        max_stall = 8;
        t             = random_tick(0);
        t.mode_wr     = 1'b1;
        t.drain_sel   = 1'b1;
        send_tick(t, CHK_PREDICT, none);
        repeat (300) begin
            send_tick(random_tick(85), CHK_PREDICT, none);
        end

        repeat (200) begin
            send_tick(random_tick(50), CHK_PREDICT, none);
        end

        hold_until_drained();

        $display("Run covered %0d ticks and %0d drained entries", ticks_sent, entries_seen);
        $display("Ring wrapped %0d times and dropped %0d entries on overflow",
                 ring_wraps, overflow_drops);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ctb_pkg.sv
rtl/core/ctb_if.sv
rtl/core/ctb_ring.sv
rtl/core/circular_event_trace_buffer_core.sv
bench/circular_event_trace_buffer_core_tb.sv
